[hdl/fen_placement_loader_top_defines.svh]
// ----------------------------------------------------------------------------
// FEN placement loader assertion macros
// Concurrent check forms used by the loader controller.
// ----------------------------------------------------------------------------
`ifndef FEN_PLACEMENT_LOADER_TOP_DEFINES_SVH
`define FEN_PLACEMENT_LOADER_TOP_DEFINES_SVH

// same-cycle implication
`define FPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fpl_pkg.sv]
// ----------------------------------------------------------------------------
// FEN placement loader package
// Payload types, control structs and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpl_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] CFG_RANK_COUNT   = 4'd0;
    localparam logic [3:0] CFG_COLUMN_COUNT = 4'd1;

    localparam logic [4:0] SIZE_MIN   = 5'd1;
    localparam logic [4:0] SIZE_MAX   = 5'd16;
    localparam logic [4:0] SIZE_RESET = 5'd8;

    typedef enum logic [1:0] {
        KIND_CELL     = 2'd0,
        KIND_BAD_SEP  = 2'd1,
        KIND_COMPLETE = 2'd2
    } fpl_kind_t;

    typedef enum logic [1:0] {
        PH_FILL = 2'd0,
        PH_SEP  = 2'd1,
        PH_DONE = 2'd2
    } fpl_phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] char_code;
    } fpl_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] rank_index;
        logic [4:0] column_index;
        logic [7:0] piece;
        logic       last;
    } fpl_out_t;

    typedef struct packed {
        logic [3:0] index;
        logic [4:0] wdata;
    } fpl_cfg_t;

    typedef struct packed {
        logic      accept;
        logic      load_pend;
        logic      advance_rank;
        logic      emit_cell;
        logic      emit_blank;
        logic      emit_flag;
        fpl_kind_t flag_kind;
    } fpl_cmd_t;

    typedef struct packed {
        fpl_phase_t phase;
        logic       is_digit;
        logic       is_sep;
        logic       rank_le1;
        logic       pend_zero;
        logic       blank_last;
        logic       slot_free;
    } fpl_stat_t;

endpackage

[hdl/fpl_chan_if.sv]
// ----------------------------------------------------------------------------
// FEN placement loader channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fpl_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/fpl_datapath.sv]
// ----------------------------------------------------------------------------
// FEN placement loader datapath
// Board size registers, fill position, owed blanks and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpl_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  fpl_pkg::fpl_in_t in_data,
    input  fpl_pkg::fpl_cmd_t cmd,
    output fpl_pkg::fpl_stat_t stat,
    fpl_chan_if.sink         cfg,
    fpl_chan_if.source       cells
);
    import fpl_pkg::*;

    logic [4:0] rank_count_reg,   rank_count_next;
    logic [4:0] column_count_reg, column_count_next;
    logic [4:0] cur_rank_reg,     cur_rank_next;
    logic [4:0] cur_col_reg,      cur_col_next;
    logic [3:0] pend_reg,         pend_next;
    fpl_phase_t phase_reg,        phase_next;
    logic [7:0] char_reg,         char_next;
    logic       out_valid_reg,    out_valid_next;
    fpl_out_t   out_data_reg,     out_data_next;
    logic [4:0] cfg_size;
    logic       col_at_end;

    function automatic logic [4:0] clamp_size(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (v == 5'd0)
        begin
            r = SIZE_MIN;
        end
        else if (v > SIZE_MAX)
        begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

    assign cfg.ready   = 1'b1;
    assign cfg_size    = clamp_size(cfg.data.wdata);
    assign col_at_end  = (cur_col_reg >= column_count_reg);

    assign stat.phase      = phase_reg;
    assign stat.is_digit   = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign stat.is_sep     = (char_reg == CH_SLASH) || (char_reg == CH_SPACE);
    assign stat.rank_le1   = (cur_rank_reg <= 5'd1);
    assign stat.pend_zero  = (pend_reg == 4'd0);
    assign stat.blank_last = (pend_reg == 4'd1) || col_at_end;
    assign stat.slot_free  = !out_valid_reg || cells.ready;

    assign cells.valid = out_valid_reg;
    assign cells.data  = out_data_reg;

    always_comb
    begin
        rank_count_next   = rank_count_reg;
        column_count_next = column_count_reg;
        cur_rank_next     = cur_rank_reg;
        cur_col_next      = cur_col_reg;
        pend_next         = pend_reg;
        phase_next        = phase_reg;
        char_next         = char_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        if (cells.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_RANK_COUNT:
                begin
                    rank_count_next = cfg_size;
                    cur_rank_next   = cfg_size;
                    cur_col_next    = SIZE_MIN;
                    pend_next       = 4'd0;
                    phase_next      = PH_FILL;
                end
                CFG_COLUMN_COUNT:
                begin
                    column_count_next = cfg_size;
                    cur_rank_next     = rank_count_reg;
                    cur_col_next      = SIZE_MIN;
                    pend_next         = 4'd0;
                    phase_next        = PH_FILL;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.accept)
        begin
            char_next = in_data.char_code;
            if (in_data.start_req)
            begin
                cur_rank_next = rank_count_reg;
                cur_col_next  = SIZE_MIN;
                pend_next     = 4'd0;
                phase_next    = PH_FILL;
            end
        end

        if (cmd.load_pend)
        begin
            pend_next = (char_reg[3:0] == 4'd0) ? 4'd1 : char_reg[3:0];
        end

        if (cmd.advance_rank)
        begin
            cur_rank_next = cur_rank_reg - 5'd1;
            cur_col_next  = SIZE_MIN;
            phase_next    = PH_FILL;
        end

        if (cmd.emit_cell || cmd.emit_blank)
        begin
            out_valid_next             = 1'b1;
            out_data_next.kind         = KIND_CELL;
            out_data_next.rank_index   = cur_rank_reg;
            out_data_next.column_index = cur_col_reg;
            out_data_next.piece        = cmd.emit_cell ? char_reg : CH_SPACE;
            out_data_next.last         = cmd.emit_cell || stat.blank_last;
            cur_col_next               = cur_col_reg + 5'd1;
            if (col_at_end)
            begin
                phase_next = PH_SEP;
            end
            if (cmd.emit_blank)
            begin
                pend_next = pend_reg - 4'd1;
            end
        end

        if (cmd.emit_flag)
        begin
            out_valid_next             = 1'b1;
            out_data_next.kind         = cmd.flag_kind;
            out_data_next.rank_index   = 5'd0;
            out_data_next.column_index = 5'd0;
            out_data_next.piece        = 8'd0;
            out_data_next.last         = 1'b1;
            pend_next                  = 4'd0;
            phase_next                 = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg   <= SIZE_RESET;
            column_count_reg <= SIZE_RESET;
            cur_rank_reg     <= SIZE_RESET;
            cur_col_reg      <= SIZE_MIN;
            pend_reg         <= 4'd0;
            phase_reg        <= PH_FILL;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rank_count_reg   <= rank_count_next;
            column_count_reg <= column_count_next;
            cur_rank_reg     <= cur_rank_next;
            cur_col_reg      <= cur_col_next;
            pend_reg         <= pend_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        out_data_reg <= out_data_next;
    end

endmodule

[hdl/fpl_ctrl.sv]
// ----------------------------------------------------------------------------
// FEN placement loader controller
// Sequences accept, decode and one result write per cycle while the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fen_placement_loader_top_defines.svh"

module fpl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpl_pkg::fpl_stat_t stat,
    output fpl_pkg::fpl_cmd_t  cmd
);
    import fpl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CELL,
        ST_BLANK,
        ST_FLAG
    } state_t;

    state_t    state_reg,     state_next;
    fpl_kind_t flag_kind_reg, flag_kind_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        flag_kind_next = flag_kind_reg;
        cmd            = '0;
        cmd.flag_kind  = flag_kind_reg;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.phase)
                    PH_FILL:
                    begin
                        if (stat.is_digit)
                        begin
                            cmd.load_pend = 1'b1;
                            state_next    = ST_BLANK;
                        end
                        else
                        begin
                            state_next = ST_CELL;
                        end
                    end
                    PH_SEP:
                    begin
                        if (!stat.is_sep)
                        begin
                            flag_kind_next = KIND_BAD_SEP;
                            state_next     = ST_FLAG;
                        end
                        else if (stat.rank_le1)
                        begin
                            flag_kind_next = KIND_COMPLETE;
                            state_next     = ST_FLAG;
                        end
                        else
                        begin
                            cmd.advance_rank = 1'b1;
                            state_next       = ST_BLANK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CELL:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_cell = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_BLANK:
            begin
                if (stat.pend_zero || (stat.phase != PH_FILL))
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.slot_free)
                begin
                    cmd.emit_blank = 1'b1;
                    if (stat.blank_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLAG:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_flag = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_kind_reg <= KIND_BAD_SEP;
        end
        else
        begin
            state_reg     <= state_next;
            flag_kind_reg <= flag_kind_next;
        end
    end

    `FPL_ASSERT_IMPLY(a_emit_slot, clk, rst_n,
        cmd.emit_cell || cmd.emit_blank || cmd.emit_flag, stat.slot_free,
        "result written while output register still full")
    `FPL_ASSERT_IMPLY(a_emit_single, clk, rst_n, 1'b1,
        $onehot0({cmd.emit_cell, cmd.emit_blank, cmd.emit_flag, cmd.accept}),
        "conflicting datapath commands")
    `FPL_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready,
        state_reg == ST_DECODE, "accepted item not decoded next cycle")

endmodule

[hdl/fen_placement_loader_top.sv]
// Flow: an accepted character is registered, decoded, then written to the result
//   register once it is free; a digit gives up to 9 results, and a separator may
//   give owed blanks or a flag. A new character is taken only in the idle state.
// Reset: size registers return to 8 by 8, fill restarts at the top rank, column 1.
// ----------------------------------------------------------------------------
// FEN placement loader top level
// Turns FEN piece-placement characters into board cell writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fen_placement_loader_top (
    input  logic       clk,
    input  logic       rst_n,
    fpl_chan_if.sink   chars,
    fpl_chan_if.sink   cfg,
    fpl_chan_if.source cells
);
    import fpl_pkg::*;

    fpl_cmd_t  cmd;
    fpl_stat_t stat;
    logic      in_ready;

    assign chars.ready = in_ready;

    fpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpl_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (chars.data),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg),
        .cells   (cells)
    );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// FEN placement loader testbench
// Feeds placement strings over the character channel and checks every cell
// item against an in-bench model of the loader. A directed table comes first,
// then random strings over random board sizes, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fpl_pkg::*;

    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int STRING_GUARD  = 400;

    localparam logic [3:0] CFG_UNUSED = 4'd15;
    localparam fpl_out_t   NO_CELL    = '0;

    typedef enum logic {
        ROW_CHAR = 1'b0,
        ROW_CFG  = 1'b1
    } row_op_t;

    typedef struct packed {
        row_op_t    op;
        logic       start_req;
        logic [7:0] char_code;
        logic [3:0] reg_index;
        logic [4:0] reg_value;
        logic       typed;
        fpl_out_t   want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    fpl_chan_if #(.payload_t(fpl_in_t))  char_bus ();
    fpl_chan_if #(.payload_t(fpl_cfg_t)) cfg_bus ();
    fpl_chan_if #(.payload_t(fpl_out_t)) cell_bus ();

    fen_placement_loader_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_bus),
        .cfg   (cfg_bus),
        .cells (cell_bus)
    );

    always #1 clk = ~clk;

    // loader model state
    logic [4:0] rank_count_q;
    logic [4:0] column_count_q;
    logic [4:0] cur_rank;
    logic [4:0] cur_col;
    logic [3:0] owed_blanks;
    fpl_phase_t fill_phase;

    fpl_out_t cell_step_q[$];
    fpl_out_t cell_expect_q[$];

    int    mismatches   = 0;
    int    cycle_count  = 0;
    int    taken_chars  = 0;
    bit    sender_quiet = 1'b0;
    string piece_set    = "pnbrqkPNBRQK";

    function automatic logic [4:0] fit_size(logic [4:0] v);
        if (v == 5'd0)
            return SIZE_MIN;
        if (v > SIZE_MAX)
            return SIZE_MAX;
        return v;
    endfunction

    function void restart_fill();
        cur_rank    = rank_count_q;
        cur_col     = 5'd1;
        owed_blanks = 4'd0;
        fill_phase  = PH_FILL;
    endfunction

    function void place_cell(logic [7:0] p);
        fpl_out_t c;
        c.kind         = KIND_CELL;
        c.rank_index   = cur_rank;
        c.column_index = cur_col;
        c.piece        = p;
        c.last         = 1'b0;
        cell_step_q.push_back(c);
        cur_col = cur_col + 5'd1;
        if (cur_col > column_count_q)
            fill_phase = PH_SEP;
    endfunction

    function void drain_owed();
        while (owed_blanks != 4'd0 && fill_phase == PH_FILL)
        begin
            owed_blanks = owed_blanks - 4'd1;
            place_cell(CH_SPACE);
        end
    endfunction

    function void end_string(fpl_kind_t k);
        fpl_out_t c;
        c      = NO_CELL;
        c.kind = k;
        cell_step_q.push_back(c);
        owed_blanks = 4'd0;
        fill_phase  = PH_DONE;
    endfunction

    function void predict_cells(fpl_in_t item, logic typed, fpl_out_t want);
        fpl_out_t tail;
        cell_step_q.delete();
        if (item.start_req)
            restart_fill();
        case (fill_phase)
            PH_FILL:
            begin
                if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE)
                begin
                    owed_blanks = (item.char_code == CH_ZERO) ? 4'd1
                                                              : 4'(item.char_code - CH_ZERO);
                    drain_owed();
                end
                else
                    place_cell(item.char_code);
            end
            PH_SEP:
            begin
                if (item.char_code != CH_SLASH && item.char_code != CH_SPACE)
                    end_string(KIND_BAD_SEP);
                else if (cur_rank <= 5'd1)
                    end_string(KIND_COMPLETE);
                else
                begin
                    cur_rank   = cur_rank - 5'd1;
                    cur_col    = 5'd1;
                    fill_phase = PH_FILL;
                    drain_owed();
                end
            end
            default:
            begin
            end
        endcase
        if (cell_step_q.size() != 0)
        begin
            tail      = cell_step_q.pop_back();
            tail.last = 1'b1;
            cell_step_q.push_back(tail);
        end
        if (typed)
            cell_expect_q.push_back(want);
        else
            foreach (cell_step_q[i])
                cell_expect_q.push_back(cell_step_q[i]);
    endfunction

    function automatic dir_row_t char_row(logic start, logic [7:0] code);
        return '{ROW_CHAR, start, code, 4'd0, 5'd0, 1'b0, NO_CELL};
    endfunction

    function automatic dir_row_t typed_row(logic start, logic [7:0] code, fpl_kind_t k,
                                           logic [4:0] r, logic [4:0] c, logic [7:0] p);
        fpl_out_t w;
        w.kind         = k;
        w.rank_index   = r;
        w.column_index = c;
        w.piece        = p;
        w.last         = 1'b1;
        return '{ROW_CHAR, start, code, 4'd0, 5'd0, 1'b1, w};
    endfunction

    function automatic dir_row_t reg_row(logic [3:0] idx, logic [4:0] value);
        return '{ROW_CFG, 1'b0, 8'd0, idx, value, 1'b0, NO_CELL};
    endfunction

    function automatic int gap_len();
        int roll;
        if (sender_quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [4:0] pick_size();
        if ($urandom_range(0, 99) < 75)
            return 5'($urandom_range(1, 4));
        case ($urandom_range(0, 4))
            0: return 5'd0;
            1: return 5'd16;
            2: return 5'd17;
            3: return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // entered and left so that the next negedge presents or drops the item
    task automatic send_char(fpl_in_t item, logic typed, fpl_out_t want);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.data  <= item;
        char_bus.valid <= 1'b1;
        do @(posedge clk); while (!char_bus.ready);
        if (item.start_req || fill_phase != PH_DONE)
            taken_chars++;
        predict_cells(item, typed, want);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (cell_expect_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [4:0] value);
        fpl_cfg_t w;
        wait_quiet();
        w.index = idx;
        w.wdata = value;
        cfg_bus.data  <= w;
        cfg_bus.valid <= 1'b1;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == CFG_RANK_COUNT)
        begin
            rank_count_q = fit_size(value);
            restart_fill();
        end
        else if (idx == CFG_COLUMN_COUNT)
        begin
            column_count_q = fit_size(value);
            restart_fill();
        end
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly well-formed placement strings; char choice follows the model state
    task automatic play_string();
        fpl_in_t item;
        int      steps;
        int      roll;
        int      room;
        bit      filling;
        steps = 0;
        do
        begin
            if (steps == 0)
                item.start_req = ($urandom_range(0, 9) != 0);
            else
                item.start_req = ($urandom_range(0, 99) < 3);
            filling = item.start_req || fill_phase == PH_FILL;
            room    = item.start_req ? int'(column_count_q)
                                     : int'(column_count_q) - int'(cur_col) + 1;
            roll    = $urandom_range(0, 99);
            if (filling)
            begin
                if (roll < 45)
                    item.char_code = piece_set[$urandom_range(0, 11)];
                else if (roll < 60)
                    item.char_code = 8'($urandom_range(0, 255));
                else if (roll < 88)
                    item.char_code = CH_ZERO + 8'($urandom_range(1, room > 9 ? 9 : room));
                else
                    item.char_code = CH_ZERO + 8'($urandom_range(0, 9));
            end
            else if (roll < 90)
                item.char_code = $urandom_range(0, 1) ? CH_SLASH : CH_SPACE;
            else
                item.char_code = 8'($urandom_range(0, 255));
            send_char(item, 1'b0, NO_CELL);
            steps++;
        end
        while (fill_phase != PH_DONE && steps < STRING_GUARD);
        repeat ($urandom_range(0, 1))
        begin
            item.start_req = 1'b0;
            item.char_code = 8'($urandom_range(0, 255));
            send_char(item, 1'b0, NO_CELL);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        fpl_out_t want;
        if (rst_n && cell_bus.valid && cell_bus.ready)
        begin
            if (cell_expect_q.size() == 0)
            begin
                $error("unexpected cell item: kind %0d rank %0d column %0d piece %0d",
                       cell_bus.data.kind, cell_bus.data.rank_index,
                       cell_bus.data.column_index, cell_bus.data.piece);
                mismatches++;
            end
            else
            begin
                want = cell_expect_q.pop_front();
                if (cell_bus.data.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, cell_bus.data.kind);
                    mismatches++;
                end
                if (cell_bus.data.rank_index !== want.rank_index)
                begin
                    $error("rank_index: expected %0d, got %0d",
                           want.rank_index, cell_bus.data.rank_index);
                    mismatches++;
                end
                if (cell_bus.data.column_index !== want.column_index)
                begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, cell_bus.data.column_index);
                    mismatches++;
                end
                if (cell_bus.data.piece !== want.piece)
                begin
                    $error("piece: expected %0d, got %0d", want.piece, cell_bus.data.piece);
                    mismatches++;
                end
                if (cell_bus.data.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, cell_bus.data.last);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure: calm stretches, short stalls, now and then a long one
    initial
    begin
        int stall_left;
        int span;
        int mode;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            span = $urandom_range(20, 150);
            mode = $urandom_range(0, 2);
            repeat (span)
            begin
                @(negedge clk);
                if (stall_left > 0)
                begin
                    cell_bus.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    cell_bus.ready <= 1'b1;
                    if (mode != 0 && $urandom_range(0, 99) < 25)
                        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(1, 3);
                end
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        fpl_in_t  item;
        int       random_base;

        rst_n          = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.data  = '0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        cell_bus.ready = 1'b0;
        rank_count_q   = SIZE_RESET;
        column_count_q = SIZE_RESET;
        restart_fill();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dir_rows.push_back(typed_row(1'b1, "r", KIND_CELL, 5'd8, 5'd1, "r"));
        dir_rows.push_back(char_row(1'b0, "7"));
        dir_rows.push_back(char_row(1'b0, " "));
        dir_rows.push_back(char_row(1'b0, "9"));
        dir_rows.push_back(char_row(1'b0, "/"));
        dir_rows.push_back(char_row(1'b0, "0"));
        dir_rows.push_back(char_row(1'b0, 8'hFF));
        dir_rows.push_back(char_row(1'b0, 8'h00));
        dir_rows.push_back(char_row(1'b0, "5"));
        dir_rows.push_back(typed_row(1'b0, "k", KIND_BAD_SEP, 5'd0, 5'd0, 8'd0));
        dir_rows.push_back(char_row(1'b0, "q"));
        dir_rows.push_back(reg_row(CFG_RANK_COUNT, 5'd0));
        dir_rows.push_back(reg_row(CFG_COLUMN_COUNT, 5'd31));
        dir_rows.push_back(char_row(1'b0, "9"));
        dir_rows.push_back(char_row(1'b0, "9"));
        dir_rows.push_back(typed_row(1'b0, "/", KIND_COMPLETE, 5'd0, 5'd0, 8'd0));
        dir_rows.push_back(reg_row(CFG_UNUSED, 5'd3));
        dir_rows.push_back(reg_row(CFG_RANK_COUNT, 5'd16));
        dir_rows.push_back(reg_row(CFG_COLUMN_COUNT, 5'd1));
        dir_rows.push_back(typed_row(1'b1, "K", KIND_CELL, 5'd16, 5'd1, "K"));
        dir_rows.push_back(typed_row(1'b0, "9", KIND_BAD_SEP, 5'd0, 5'd0, 8'd0));
        dir_rows.push_back(char_row(1'b1, "3"));
        dir_rows.push_back(char_row(1'b0, "/"));
        dir_rows.push_back(char_row(1'b0, " "));
        dir_rows.push_back(typed_row(1'b0, "B", KIND_BAD_SEP, 5'd0, 5'd0, 8'd0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CFG)
                write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
            else
            begin
                item.start_req = dir_rows[i].start_req;
                item.char_code = dir_rows[i].char_code;
                send_char(item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        random_base = taken_chars;
        while (taken_chars - random_base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(4'($urandom_range(2, 15)), 5'($urandom_range(0, 31)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_RANK_COUNT, pick_size());
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_COLUMN_COUNT, pick_size());
            end
            sender_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) play_string();
        end

        wait_quiet();
        if (mismatches == 0 && cell_expect_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/fpl_pkg.sv
hdl/fpl_chan_if.sv
hdl/fpl_datapath.sv
hdl/fpl_ctrl.sv
hdl/fen_placement_loader_top.sv
sim/testbench.sv
